### hw/rtl/mlwf_pkg.sv
// Shared types, command constants and helpers for the memory LCD line write framer.
// Depends on nothing; used by the front, queue, back and top modules.
package mlwf_pkg;

   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_DATA  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [7:0] CMD_WRITE = 8'h80;
   localparam logic [7:0] CMD_VCOM  = 8'h40;
   localparam logic [7:0] CMD_CLEAR = 8'h20;
   localparam logic [7:0] TRAILER   = 8'h00;
   localparam logic [7:0] BPL_RESET = 8'd50;

   typedef enum logic [1:0] {
      KIND_BEGIN,
      KIND_DATA,
      KIND_CLEAR
   } job_kind_type;

   // One classified item: everything the back end needs to emit its bytes.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   first_byte;
      logic [7:0]   addr_byte;
      logic         line_wrap;
      logic         frame_close;
   } job_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

endpackage

### hw/rtl/mlwf_front.sv
// Front end: accepts items, tracks frame, line and VCOM state, and classifies each
// item into a job for the queue. Depends on mlwf_pkg.
module mlwf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       bytes_per_line,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_start_line,
   input  logic [7:0]       req_pixel_byte,
   input  logic             req_last_byte,
   input  logic             q_full,
   output logic             push_valid,
   output mlwf_pkg::job_type push_job
);

   logic       vcom_ff, vcom_in;
   logic [7:0] line_ff, line_in;
   logic [7:0] byte_ff, byte_in;
   logic       frame_open_ff, frame_open_in;

   logic       accept;
   logic [7:0] byte_next;
   logic [7:0] line_next;
   logic       line_wrap;
   logic [7:0] vcom_bits;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign byte_next = byte_ff + 8'd1;
   assign line_next = line_ff + 8'd1;
   assign line_wrap = (byte_next == bytes_per_line);
   assign vcom_bits = vcom_ff ? mlwf_pkg::CMD_VCOM : 8'h00;

   always_comb begin
      vcom_in       = vcom_ff;
      line_in       = line_ff;
      byte_in       = byte_ff;
      frame_open_in = frame_open_ff;
      push_valid    = 1'b0;

      push_job.kind        = mlwf_pkg::KIND_DATA;
      push_job.first_byte  = mlwf_pkg::reverse8(req_pixel_byte);
      push_job.addr_byte   = mlwf_pkg::reverse8(line_next);
      push_job.line_wrap   = line_wrap;
      push_job.frame_close = req_last_byte;

      if (accept) begin
         case (req_mode)
            mlwf_pkg::MODE_BEGIN: begin
               push_valid          = 1'b1;
               push_job.kind       = mlwf_pkg::KIND_BEGIN;
               push_job.first_byte = mlwf_pkg::CMD_WRITE | vcom_bits;
               push_job.addr_byte  = mlwf_pkg::reverse8(req_start_line);
               vcom_in             = !vcom_ff;
               line_in             = req_start_line;
               byte_in             = 8'd0;
               frame_open_in       = 1'b1;
            end
            mlwf_pkg::MODE_DATA: begin
               // drop data that arrives outside a frame
               if (frame_open_ff) begin
                  push_valid = 1'b1;
                  if (line_wrap) begin
                     byte_in = 8'd0;
                     line_in = line_next;
                  end else begin
                     byte_in = byte_next;
                  end
                  if (req_last_byte) begin
                     frame_open_in = 1'b0;
                  end
               end
            end
            mlwf_pkg::MODE_CLEAR: begin
               push_valid          = 1'b1;
               push_job.kind       = mlwf_pkg::KIND_CLEAR;
               push_job.first_byte = mlwf_pkg::CMD_CLEAR | vcom_bits;
               vcom_in             = !vcom_ff;
               frame_open_in       = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcom_ff       <= 1'b1;
         line_ff       <= 8'd0;
         byte_ff       <= 8'd0;
         frame_open_ff <= 1'b0;
      end else begin
         vcom_ff       <= vcom_in;
         line_ff       <= line_in;
         byte_ff       <= byte_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

### hw/rtl/mlwf_queue.sv
// Short job queue between the front and back ends.
// Depends on mlwf_pkg for the job type.
module mlwf_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mlwf_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mlwf_pkg::job_type head_job
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mlwf_pkg::job_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hw/rtl/mlwf_back.sv
// Back end: expands each queued job into one to four wire bytes and holds them
// in the result register. Depends on mlwf_pkg.
module mlwf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  mlwf_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_wire_byte,
   output logic              rsp_select_start,
   output logic              rsp_select_end,
   output logic              rsp_run_last
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       sel_start_ff, sel_start_in;
   logic       sel_end_ff, sel_end_in;
   logic       run_last_ff, run_last_in;

   logic       out_free;
   logic       advance;
   logic [7:0] cur_byte;
   logic       cur_ss, cur_se, cur_last;

   assign out_free = !valid_ff || rsp_ready;
   assign advance  = out_free && head_valid;
   assign pop      = advance && cur_last;

   // byte sequence of the head job at the current step
   always_comb begin
      cur_byte = mlwf_pkg::TRAILER;
      cur_ss   = 1'b0;
      cur_se   = 1'b0;
      cur_last = 1'b0;
      case (head_job.kind)
         mlwf_pkg::KIND_BEGIN: begin
            if (step_ff == 2'd0) begin
               cur_byte = head_job.first_byte;
               cur_ss   = 1'b1;
            end else begin
               cur_byte = head_job.addr_byte;
               cur_last = 1'b1;
            end
         end
         mlwf_pkg::KIND_CLEAR: begin
            if (step_ff == 2'd0) begin
               cur_byte = head_job.first_byte;
               cur_ss   = 1'b1;
            end else begin
               cur_se   = 1'b1;
               cur_last = 1'b1;
            end
         end
         mlwf_pkg::KIND_DATA: begin
            case (step_ff)
               2'd0: begin
                  cur_byte = head_job.first_byte;
                  cur_last = !head_job.line_wrap && !head_job.frame_close;
               end
               2'd1: begin
                  if (!head_job.line_wrap) begin
                     cur_se   = 1'b1;
                     cur_last = 1'b1;
                  end
               end
               2'd2: begin
                  cur_byte = head_job.addr_byte;
                  cur_last = !head_job.frame_close;
               end
               default: begin
                  cur_se   = 1'b1;
                  cur_last = 1'b1;
               end
            endcase
         end
         default: begin
            cur_byte = head_job.first_byte;
            cur_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      sel_start_in = sel_start_ff;
      sel_end_in   = sel_end_ff;
      run_last_in  = run_last_ff;
      if (out_free) begin
         valid_in = head_valid;
      end
      if (advance) begin
         byte_in      = cur_byte;
         sel_start_in = cur_ss;
         sel_end_in   = cur_se;
         run_last_in  = cur_last;
         step_in      = cur_last ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      sel_start_ff <= sel_start_in;
      sel_end_ff   <= sel_end_in;
      run_last_ff  <= run_last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_wire_byte    = byte_ff;
   assign rsp_select_start = sel_start_ff;
   assign rsp_select_end   = sel_end_ff;
   assign rsp_run_last     = run_last_ff;

endmodule

### hw/rtl/memory_lcd_line_write_framer_top.sv
// Top level of the memory LCD line write framer: register port, front end,
// job queue and back end. Depends on mlwf_pkg, mlwf_front, mlwf_queue, mlwf_back.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   mode, start_line, pixel_byte, last_byte
//   rsp_      out        rsp_valid/rsp_ready   wire_byte, select_start, select_end, run_last
//   register  in         psel/penable/pready   bytes_per_line at byte address 0
//
// The front end takes one item per cycle while the job queue has room.
// The back end emits one byte per cycle while rsp_ready is high: two for begin and clear,
// one to four for data, so a pixel byte gives one wire byte unless it ends a line or the frame.
// No clearing pass follows reset.
// A stalled result holds in the output register; the queue lets items enter meanwhile until it is full.
module memory_lcd_line_write_framer_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_start_line,
   input  logic [7:0]  req_pixel_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_wire_byte,
   output logic        rsp_select_start,
   output logic        rsp_select_end,
   output logic        rsp_run_last
);

   logic [7:0]        bpl_ff, bpl_in;
   logic              q_full, push_valid, pop, head_valid;
   mlwf_pkg::job_type push_job, head_job;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {24'd0, bpl_ff} : 32'd0;

   always_comb begin
      bpl_in = bpl_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         bpl_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff <= mlwf_pkg::BPL_RESET;
      end else begin
         bpl_ff <= bpl_in;
      end
   end

   mlwf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .bytes_per_line (bpl_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_start_line (req_start_line),
      .req_pixel_byte (req_pixel_byte),
      .req_last_byte  (req_last_byte),
      .q_full         (q_full),
      .push_valid     (push_valid),
      .push_job       (push_job)
   );

   mlwf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mlwf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wire_byte    (rsp_wire_byte),
      .rsp_select_start (rsp_select_start),
      .rsp_select_end   (rsp_select_end),
      .rsp_run_last     (rsp_run_last)
   );

   // select falls only on the closing byte of an item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_select_end |-> rsp_run_last)
      else $error("select_end without run_last");

   // a command byte that raises select is never the whole item
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_select_start |-> !rsp_run_last)
      else $error("select_start on last result");

   a_start_is_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_select_start |-> rsp_wire_byte[7] || rsp_wire_byte[5])
      else $error("select_start on a non-command byte");

   a_queue_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && (!rsp_valid || rsp_ready))
      else $error("job popped without output slot");

endmodule

### test/tb_top.sv
// Testbench for the memory LCD line write framer: directed table, then random frames and a long line.
// Depends on mlwf_pkg and memory_lcd_line_write_framer_top; checks every result byte
// against typed table rows or an in-bench model of the framing, command bytes and VCOM toggling.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD    = 10;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          RUN_LIMIT     = 3_000_000;
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam logic [2:0]  BPL_ADDR      = 3'd0;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       sel_start;
      logic       sel_end;
      logic       run_last;
   } frame_byte_type;

   localparam frame_byte_type NO_BYTE = '0;

   typedef struct packed {
      logic [1:0]           mode;
      logic [7:0]           start;
      logic [7:0]           pix;
      logic                 last;
      logic                 typed;
      logic [2:0]           cnt;
      frame_byte_type [0:3] want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = mlwf_pkg::MODE_BEGIN;
   logic [7:0]  req_start_line = '0;
   logic [7:0]  req_pixel_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_wire_byte;
   logic        rsp_select_start;
   logic        rsp_select_end;
   logic        rsp_run_last;

   // framer state as the bench sees it
   logic        vcom_q;
   logic [7:0]  line_q;
   logic [7:0]  count_q;
   logic        open_q;
   logic [7:0]  bpl_q;

   frame_byte_type wire_expect[$];
   stim_row_type   dir_tab[23];
   bit             fail_seen = 1'b0;
   bit             calm = 1'b0;
   int             stall_left = 0;

   memory_lcd_line_write_framer_top u_dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic frame_byte_type fb(logic [7:0] b, logic ss, logic se, logic rl);
      frame_byte_type r;
      r.wire_byte = b;
      r.sel_start = ss;
      r.sel_end   = se;
      r.run_last  = rl;
      return r;
   endfunction

   function automatic logic [7:0] mirror8(logic [7:0] v);
      logic [7:0] r;
      r = {<<{v}};
      return r;
   endfunction

   // Work out the bytes one item puts on the wire and advance the state.
   task automatic frame_predict(input logic [1:0] mode, input logic [7:0] start,
                                input logic [7:0] pix, input logic last,
                                input bit keep, output int n);
      frame_byte_type out [4];
      logic [7:0]     vbit;
      vbit = vcom_q ? mlwf_pkg::CMD_VCOM : 8'h00;
      n = 0;
      case (mode)
         mlwf_pkg::MODE_BEGIN: begin
            out[0] = fb(mlwf_pkg::CMD_WRITE | vbit, 1'b1, 1'b0, 1'b0);
            out[1] = fb(mirror8(start), 1'b0, 1'b0, 1'b0);
            n = 2;
            vcom_q  = ~vcom_q;
            line_q  = start;
            count_q = '0;
            open_q  = 1'b1;
         end
         mlwf_pkg::MODE_DATA: begin
            if (open_q) begin
               out[0] = fb(mirror8(pix), 1'b0, 1'b0, 1'b0);
               n = 1;
               count_q = count_q + 8'd1;
               if (count_q == bpl_q) begin
                  count_q = '0;
                  line_q  = line_q + 8'd1;
                  out[1] = fb(mlwf_pkg::TRAILER, 1'b0, 1'b0, 1'b0);
                  out[2] = fb(mirror8(line_q), 1'b0, 1'b0, 1'b0);
                  n = 3;
               end
               if (last) begin
                  out[n] = fb(mlwf_pkg::TRAILER, 1'b0, 1'b1, 1'b0);
                  n = n + 1;
                  open_q = 1'b0;
               end
            end
         end
         mlwf_pkg::MODE_CLEAR: begin
            out[0] = fb(mlwf_pkg::CMD_CLEAR | vbit, 1'b1, 1'b0, 1'b0);
            out[1] = fb(mlwf_pkg::TRAILER, 1'b0, 1'b1, 1'b0);
            n = 2;
            vcom_q = ~vcom_q;
            open_q = 1'b0;
         end
         default: ;
      endcase
      if (n > 0) out[n - 1].run_last = 1'b1;
      if (keep) begin
         for (int k = 0; k < n; k++) wire_expect.push_back(out[k]);
      end
   endtask

   // Offer one item, hold it until taken, then predict its bytes.
   task automatic drive_item(input logic [1:0] mode, input logic [7:0] start,
                             input logic [7:0] pix, input logic last,
                             input bit keep, output int n);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_start_line <= start;
      req_pixel_byte <= pix;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      frame_predict(mode, start, pix, last, keep, n);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (wire_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Wait for the block to go idle, write the line length and read it back.
   task automatic set_line_length(input logic [7:0] bpl);
      logic [31:0] rd;
      settle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= BPL_ADDR;
      pwdata  <= {24'd0, bpl};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      bpl_q = bpl;
      @(posedge clock);
      csr_read(BPL_ADDR, rd);
      if (rd[7:0] !== bpl) begin
         $error("bytes_per_line readback: expected %0d, got %0d", bpl, rd[7:0]);
         fail_seen = 1'b1;
      end
   endtask

   // Mostly whole frames with random content, some clears, noise and stray data.
   task automatic random_phase(input logic [7:0] bpl, input int quota);
      int          done;
      int          n;
      int          len;
      int          pick;
      logic [7:0]  start;
      settle();
      set_line_length(bpl);
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            start = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            drive_item(mlwf_pkg::MODE_BEGIN, start, 8'($urandom), 1'($urandom), 1'b1, n);
            done = done + 1;
            len = $urandom_range(1, (bpl == 0 || bpl > 8) ? 20 : 3 * bpl + 1);
            for (int k = 1; k <= len; k++) begin
               drive_item(mlwf_pkg::MODE_DATA, 8'($urandom), 8'($urandom),
                          (k == len) && ($urandom_range(0, 9) != 0), 1'b1, n);
               if (n > 0) done = done + 1;
            end
         end else if (pick < 85) begin
            drive_item(mlwf_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                       1'b1, n);
            done = done + 1;
         end else if (pick < 92) begin
            drive_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1, n);
         end else begin
            drive_item(mlwf_pkg::MODE_DATA, 8'($urandom), 8'($urandom), 1'($urandom),
                       1'b1, n);
            if (n > 0) done = done + 1;
         end
      end
   endtask

   // Result side: random stall bursts unless the run is in its calm stretch.
   always @(posedge clock) begin
      if (calm) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wire_expect.size() == 0) begin
            $error("unexpected result byte %h", rsp_wire_byte);
            fail_seen = 1'b1;
         end else begin
            want = wire_expect.pop_front();
            if (rsp_wire_byte !== want.wire_byte) begin
               $error("wire_byte: expected %h, got %h", want.wire_byte, rsp_wire_byte);
               fail_seen = 1'b1;
            end
            if (rsp_select_start !== want.sel_start) begin
               $error("select_start: expected %b, got %b", want.sel_start, rsp_select_start);
               fail_seen = 1'b1;
            end
            if (rsp_select_end !== want.sel_end) begin
               $error("select_end: expected %b, got %b", want.sel_end, rsp_select_end);
               fail_seen = 1'b1;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_run_last);
               fail_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [31:0] rd;
      int          n;
      logic [7:0]  start;

      vcom_q  = 1'b1;
      line_q  = '0;
      count_q = '0;
      open_q  = 1'b0;
      bpl_q   = mlwf_pkg::BPL_RESET;

      // Directed rows, line length 2; typed bytes follow from the framing rules.
      dir_tab[0]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'hFF, 1'b1, 1'b1, 3'd0, {4{NO_BYTE}}};
      dir_tab[1]  = '{MODE_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd0, {4{NO_BYTE}}};
      dir_tab[2]  = '{mlwf_pkg::MODE_CLEAR, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'h60, 1'b1, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b1, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[3]  = '{mlwf_pkg::MODE_BEGIN, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'h80, 1'b1, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b0, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[4]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h01, 1'b0, 1'b1, 3'd1,
                      {fb(8'h80, 1'b0, 1'b0, 1'b1), NO_BYTE, NO_BYTE, NO_BYTE}};
      dir_tab[5]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'hFF, 1'b0, 1'b1, 3'd3,
                      {fb(8'hFF, 1'b0, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b0, 1'b0),
                       fb(8'h80, 1'b0, 1'b0, 1'b1), NO_BYTE}};
      dir_tab[6]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h00, 1'b1, 1'b1, 3'd2,
                      {fb(8'h00, 1'b0, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b1, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[7]  = '{mlwf_pkg::MODE_BEGIN, 8'hFF, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'hC0, 1'b1, 1'b0, 1'b0), fb(8'hFF, 1'b0, 1'b0, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[8]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'hAA, 1'b0, 1'b1, 3'd1,
                      {fb(8'h55, 1'b0, 1'b0, 1'b1), NO_BYTE, NO_BYTE, NO_BYTE}};
      // last byte that also ends the line, address wraps past 255
      dir_tab[9]  = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h55, 1'b1, 1'b1, 3'd4,
                      {fb(8'hAA, 1'b0, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b0, 1'b0),
                       fb(8'h00, 1'b0, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b1, 1'b1)}};
      dir_tab[10] = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h12, 1'b0, 1'b1, 3'd0, {4{NO_BYTE}}};
      dir_tab[11] = '{mlwf_pkg::MODE_BEGIN, 8'h80, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'h80, 1'b1, 1'b0, 1'b0), fb(8'h01, 1'b0, 1'b0, 1'b1),
                       NO_BYTE, NO_BYTE}};
      // begin on top of an open frame
      dir_tab[12] = '{mlwf_pkg::MODE_BEGIN, 8'h01, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'hC0, 1'b1, 1'b0, 1'b0), fb(8'h80, 1'b0, 1'b0, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[13] = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h0F, 1'b0, 1'b1, 3'd1,
                      {fb(8'hF0, 1'b0, 1'b0, 1'b1), NO_BYTE, NO_BYTE, NO_BYTE}};
      // clear on top of an open frame
      dir_tab[14] = '{mlwf_pkg::MODE_CLEAR, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2,
                      {fb(8'h20, 1'b1, 1'b0, 1'b0), fb(8'h00, 1'b0, 1'b1, 1'b1),
                       NO_BYTE, NO_BYTE}};
      dir_tab[15] = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h3C, 1'b1, 1'b1, 3'd0, {4{NO_BYTE}}};
      dir_tab[16] = '{MODE_UNUSED, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0, {4{NO_BYTE}}};
      dir_tab[17] = '{mlwf_pkg::MODE_BEGIN, 8'h7E, 8'h00, 1'b0, 1'b0, 3'd0, {4{NO_BYTE}}};
      dir_tab[18] = '{mlwf_pkg::MODE_DATA, 8'h00, 8'h81, 1'b0, 1'b0, 3'd0, {4{NO_BYTE}}};
      dir_tab[19] = '{mlwf_pkg::MODE_DATA, 8'hFF, 8'h3C, 1'b0, 1'b0, 3'd0, {4{NO_BYTE}}};
      dir_tab[20] = '{mlwf_pkg::MODE_DATA, 8'h00, 8'hC3, 1'b1, 1'b0, 3'd0, {4{NO_BYTE}}};
      dir_tab[21] = '{mlwf_pkg::MODE_BEGIN, 8'hA5, 8'hFF, 1'b1, 1'b0, 3'd0, {4{NO_BYTE}}};
      dir_tab[22] = '{mlwf_pkg::MODE_DATA, 8'h5A, 8'h5A, 1'b0, 1'b0, 3'd0, {4{NO_BYTE}}};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_read(BPL_ADDR, rd);
      if (rd[7:0] !== mlwf_pkg::BPL_RESET) begin
         $error("bytes_per_line after reset: expected %0d, got %0d",
                mlwf_pkg::BPL_RESET, rd[7:0]);
         fail_seen = 1'b1;
      end
      @(posedge clock);
      set_line_length(8'd2);

      foreach (dir_tab[i]) begin
         drive_item(dir_tab[i].mode, dir_tab[i].start, dir_tab[i].pix, dir_tab[i].last,
                    !dir_tab[i].typed, n);
         if (dir_tab[i].typed) begin
            for (int k = 0; k < dir_tab[i].cnt; k++) wire_expect.push_back(dir_tab[i].want[k]);
         end
      end

      // the directed frame is left open, so the next line length starts mid-line
      random_phase(8'd1, 10);

      // One long line: start at 255, lower to zero mid-line, run the count through 256.
      set_line_length(8'd255);
      start = ($urandom_range(0, 1) == 0) ? 8'hFE : 8'($urandom);
      drive_item(mlwf_pkg::MODE_BEGIN, start, 8'($urandom), 1'b0, 1'b1, n);
      for (int k = 0; k < 10; k++)
         drive_item(mlwf_pkg::MODE_DATA, 8'($urandom), 8'($urandom), 1'b0, 1'b1, n);
      set_line_length(8'd0);
      for (int k = 0; k < 245; k++)
         drive_item(mlwf_pkg::MODE_DATA, 8'($urandom), 8'($urandom), 1'b0, 1'b1, n);
      drive_item(mlwf_pkg::MODE_DATA, 8'($urandom), 8'($urandom), 1'b1, 1'b1, n);

      random_phase(8'($urandom_range(2, 8)), 10);

      // last stretch runs without idling on either side
      calm = 1'b1;
      random_phase(8'd3, 12);

      settle();
      if (!fail_seen && wire_expect.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/mlwf_pkg.sv
hw/rtl/mlwf_front.sv
hw/rtl/mlwf_queue.sv
hw/rtl/mlwf_back.sv
hw/rtl/memory_lcd_line_write_framer_top.sv
test/tb_top.sv
